[hw/rtl/rgb_led_strip_frame_builder_assert.svh]
// Assertion macros of the frame builder RTL, used by the back stage
`ifndef RGB_LED_STRIP_FRAME_BUILDER_ASSERT_SVH
`define RGB_LED_STRIP_FRAME_BUILDER_ASSERT_SVH

// a holds at an edge, so b must hold at that edge
`define RGBFB_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rgbfb: same-cycle implication violated");

// a holds at an edge, so b must hold at the next edge
`define RGBFB_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rgbfb: next-cycle implication violated");

`endif

[hw/rtl/rgbfb_pkg.sv]
// Shared types and constants of the LED strip frame builder
`timescale 1ns / 1ps

package rgbfb_pkg;

    localparam int DEFAULT_MAX_LEDS = 256;
    localparam int QUEUE_DEPTH      = 2;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int COLOUR_W = 24;
    localparam int BYTE_W   = 8;
    localparam int BRIGHT_W = 8;
    localparam int COUNT_W  = 9;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd2;

    localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET = 8'd31;
    localparam logic [BRIGHT_W-1:0] LEVEL_MAX        = 8'd31;
    localparam logic [BYTE_W-1:0]   LEVEL_MARK       = 8'hE0;
    localparam logic [BYTE_W-1:0]   LEVEL_FULL       = 8'hFF;
    localparam logic [4:0]          LEVEL_MASK       = 5'h1F;

    localparam int START_BYTES  = 4;
    localparam int END_ROUND    = 15;
    localparam int END_SHIFT    = 4;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_CLEAR,
        OP_BYTE,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [INDEX_W-1:0]  pixel_index;
        logic [COLOUR_W-1:0] colour;
    } cmd_t;

endpackage

[hw/rtl/rgbfb_if.sv]
// Request and response channel interfaces of the frame builder
`timescale 1ns / 1ps

interface rgbfb_req_if;
    import rgbfb_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [INDEX_W-1:0]  pixel_index;
    logic [COLOUR_W-1:0] colour;

    modport source (output valid, output kind, output pixel_index, output colour,
                    input ready);
    modport sink   (input valid, input kind, input pixel_index, input colour,
                    output ready);
endinterface

interface rgbfb_rsp_if;
    import rgbfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              byte_valid;
    logic              last_byte;
    logic              refused;

    modport source (output valid, output frame_byte, output byte_valid,
                    output last_byte, output refused, input ready);
    modport sink   (input valid, input frame_byte, input byte_valid,
                    input last_byte, input refused, output ready);
endinterface

[hw/rtl/rgbfb_front.sv]
// Front stage: accept requests, decode the kind and check the pixel index
`timescale 1ns / 1ps

module rgbfb_front #(
    parameter int MAX_LEDS = rgbfb_pkg::DEFAULT_MAX_LEDS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    rgbfb_req_if.sink                             req,
    input  logic [$clog2(MAX_LEDS+1)-1:0]         used_count,
    output logic                                  push,
    output rgbfb_pkg::cmd_t                       push_data,
    input  logic                                  push_ready
);
    import rgbfb_pkg::*;

    logic stage_valid_reg;
    cmd_t stage_reg;
    cmd_t cmd_next;
    logic accept;

    always_comb
    begin
        cmd_next.pixel_index = req.pixel_index;
        cmd_next.colour      = req.colour;
        cmd_next.in_range    = 32'(req.pixel_index) < 32'(used_count);
        case (req.kind)
            KIND_WRITE: cmd_next.op = OP_WRITE;
            KIND_CLEAR: cmd_next.op = OP_CLEAR;
            KIND_BYTE:  cmd_next.op = OP_BYTE;
            default:    cmd_next.op = OP_NONE;
        endcase
    end

    assign req.ready = !stage_valid_reg || push_ready;
    assign accept    = req.valid && req.ready;
    assign push      = stage_valid_reg;
    assign push_data = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= cmd_next;
        end
    end

endmodule

[hw/rtl/rgbfb_queue.sv]
// Short command queue between the front and back stages
`timescale 1ns / 1ps

module rgbfb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rgbfb_pkg::cmd_t push_data,
    output logic            push_ready,
    input  logic            pop,
    output rgbfb_pkg::cmd_t head,
    output logic            head_valid
);
    import rgbfb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entries[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/rgbfb_back.sv]
// Back stage: pixel store, frame sequencer, configuration and result register
`timescale 1ns / 1ps
`include "rgb_led_strip_frame_builder_assert.svh"

module rgbfb_back #(
    parameter int MAX_LEDS = rgbfb_pkg::DEFAULT_MAX_LEDS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rgbfb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rgbfb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  rgbfb_pkg::cmd_t                       head,
    input  logic                                  head_valid,
    output logic                                  pop,
    output logic [$clog2(MAX_LEDS+1)-1:0]         used_count,
    rgbfb_rsp_if.source                           rsp
);
    import rgbfb_pkg::*;

    localparam int AW      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W   = $clog2(MAX_LEDS + 1);
    localparam int LEN_MAX = START_BYTES + 4 * MAX_LEDS + (MAX_LEDS + END_ROUND) / 16 + 1;
    localparam int POS_W   = $clog2(LEN_MAX + 1);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         sweep_addr_reg;
    logic                  frame_open_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [BRIGHT_W-1:0]   brightness_reg;
    logic [COUNT_W-1:0]    led_count_reg;

    logic                  rsp_valid_reg;
    logic [BYTE_W-1:0]     frame_byte_reg;
    logic                  byte_valid_reg;
    logic                  last_byte_reg;
    logic                  refused_reg;

    logic [COLOUR_W-1:0]   pixel_mem [MAX_LEDS];
    logic [COLOUR_W-1:0]   rd_data_reg;

    logic                  out_free;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COLOUR_W-1:0]   mem_wdata;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  load;
    logic                  start_sweep;
    logic [BYTE_W-1:0]     ld_byte;
    logic                  ld_valid;
    logic                  ld_last;
    logic                  ld_refused;

    logic [CNT_W+4:0]      n_ext;
    logic [POS_W-1:0]      frame_len;
    logic [POS_W-1:0]      four_n;
    logic [POS_W-1:0]      pos_eff;
    logic [POS_W-1:0]      offset;
    logic [POS_W-1:0]      pos_inc;
    logic                  in_data;
    logic                  is_last;
    logic [BYTE_W-1:0]     level_byte;
    logic [BYTE_W-1:0]     data_byte;

    assign used_count = (32'(led_count_reg) > MAX_LEDS) ? CNT_W'(MAX_LEDS)
                                                        : CNT_W'(led_count_reg);

    assign n_ext     = (CNT_W+5)'(used_count);
    assign four_n    = POS_W'(used_count) << 2;
    assign frame_len = POS_W'(START_BYTES) + four_n
                     + POS_W'((n_ext + (CNT_W+5)'(END_ROUND)) >> END_SHIFT) + POS_W'(1);
    assign pos_eff   = frame_open_reg ? pos_reg : '0;
    assign offset    = pos_eff - POS_W'(START_BYTES);
    assign pos_inc   = pos_eff + 1'b1;
    assign in_data   = (pos_eff >= POS_W'(START_BYTES)) && (offset < four_n);
    assign is_last   = pos_inc >= frame_len;
    assign rd_addr   = AW'(offset >> 2);

    assign level_byte = (brightness_reg > LEVEL_MAX) ? LEVEL_FULL
                      : (LEVEL_MARK | {3'b000, brightness_reg[4:0] & LEVEL_MASK});

    always_comb
    begin
        case (offset[1:0])
            2'd0:    data_byte = level_byte;
            2'd1:    data_byte = rd_data_reg[7:0];
            2'd2:    data_byte = rd_data_reg[15:8];
            default: data_byte = rd_data_reg[23:16];
        endcase
    end

    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = sweep_addr_reg;
        mem_wdata   = '0;
        rd_en       = 1'b0;
        pop         = 1'b0;
        load        = 1'b0;
        start_sweep = 1'b0;
        ld_byte     = '0;
        ld_valid    = 1'b0;
        ld_last     = 1'b0;
        ld_refused  = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    case (head.op)
                        OP_WRITE:
                        begin
                            load = 1'b1;
                            pop  = 1'b1;
                            if (frame_open_reg || !head.in_range)
                            begin
                                ld_refused = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(head.pixel_index);
                                mem_wdata = head.colour;
                            end
                        end
                        OP_CLEAR:
                        begin
                            load = 1'b1;
                            pop  = 1'b1;
                            if (frame_open_reg)
                            begin
                                ld_refused = 1'b1;
                            end
                            else
                            begin
                                start_sweep = 1'b1;
                            end
                        end
                        OP_BYTE:
                        begin
                            rd_en = 1'b1;
                        end
                        default:
                        begin
                            load = 1'b1;
                            pop  = 1'b1;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    pop      = 1'b1;
                    ld_byte  = in_data ? data_byte : '0;
                    ld_valid = 1'b1;
                    ld_last  = is_last;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= pixel_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RESET;
            led_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS:
                begin
                    brightness_reg <= cfg_data[BRIGHT_W-1:0];
                end
                CFG_LED_COUNT:
                begin
                    if (!frame_open_reg)
                    begin
                        led_count_reg <= cfg_data[COUNT_W-1:0];
                    end
                end
                default:
                begin
                    led_count_reg <= led_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            frame_open_reg <= 1'b0;
            pos_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            frame_byte_reg <= '0;
            byte_valid_reg <= 1'b0;
            last_byte_reg  <= 1'b0;
            refused_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                rsp_valid_reg  <= 1'b1;
                frame_byte_reg <= ld_byte;
                byte_valid_reg <= ld_valid;
                last_byte_reg  <= ld_last;
                refused_reg    <= ld_refused;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_SWEEP:
                begin
                    if (sweep_addr_reg == AW'(MAX_LEDS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    sweep_addr_reg <= '0;
                    if (start_sweep)
                    begin
                        state_reg <= ST_SWEEP;
                    end
                    else if (rd_en)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (load)
                    begin
                        state_reg      <= ST_IDLE;
                        frame_open_reg <= !is_last;
                        pos_reg        <= is_last ? '0 : pos_inc;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.frame_byte = frame_byte_reg;
    assign rsp.byte_valid = byte_valid_reg;
    assign rsp.last_byte  = last_byte_reg;
    assign rsp.refused    = refused_reg;

    `RGBFB_ASSERT_IMPL(a_pos_in_frame, clk, rst_n, frame_open_reg, pos_reg < frame_len)
    `RGBFB_ASSERT_IMPL(a_no_store_write_open, clk, rst_n, mem_we, !frame_open_reg)
    `RGBFB_ASSERT_NEXT(a_close_after_last, clk, rst_n, load && ld_last, !frame_open_reg)
    `RGBFB_ASSERT_IMPL(a_pop_needs_room, clk, rst_n, pop, out_free && head_valid)

endmodule

[hw/rtl/rgb_led_strip_frame_builder.sv]
// Each request passes the front stage register and the queue to the registered answer.
// Throughput: one request per cycle unless the queue or answer stalls, but a frame byte
// passes ST_IDLE, then ST_EMIT in the back stage for the registered pixel memory read; a
// clear holds the back stage in ST_SWEEP while it zeroes the store one entry per cycle.
// Reset: control and configuration clear at once (brightness 31, count 0); the store is
// then zeroed in a sweep of every entry, while requests queue but do not execute.
`timescale 1ns / 1ps

module rgb_led_strip_frame_builder #(
    parameter int MAX_LEDS = rgbfb_pkg::DEFAULT_MAX_LEDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rgbfb_req_if.sink                         req,
    rgbfb_rsp_if.source                       rsp,
    input  logic                              cfg_we,
    input  logic [rgbfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbfb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rgbfb_pkg::*;

    logic [$clog2(MAX_LEDS+1)-1:0] used_count;
    logic                          push;
    cmd_t                          push_data;
    logic                          push_ready;
    logic                          pop;
    cmd_t                          head;
    logic                          head_valid;

    rgbfb_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .used_count (used_count),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    rgbfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    rgbfb_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .used_count (used_count),
        .rsp        (rsp)
    );

endmodule

[tb/sv/rgb_led_strip_frame_builder_tb.sv]
// Self-checking testbench of the LED strip frame builder with random handshake idling
`timescale 1ns / 1ps

module rgb_led_strip_frame_builder_tb;
    import rgbfb_pkg::*;

    localparam int LED_SLOTS    = DEFAULT_MAX_LEDS;
    localparam int RANDOM_ITEMS = 720;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;
    localparam int SHOWN_ERRORS = 10;
    localparam int FULL_BYTES   = 40;

    typedef struct packed {
        op_t                 kind;
        logic [INDEX_W-1:0]  pixel_index;
        logic [COLOUR_W-1:0] colour;
    } strip_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              byte_valid;
        logic              last_byte;
        logic              refused;
    } strip_answer_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgbfb_req_if req_ch ();
    rgbfb_rsp_if rsp_ch ();

    rgb_led_strip_frame_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // strip model state
    logic [COLOUR_W-1:0] pixel_mem [LED_SLOTS];
    int                  frame_pos;
    bit                  frame_is_open;
    logic [BRIGHT_W-1:0] level_reg;
    logic [COUNT_W-1:0]  leds_reg;

    strip_req_t    send_queue[$];
    strip_answer_t expected_answers[$];

    bit req_taken;
    int source_idle_pct;
    int sink_idle_pct;
    int plan_pos;
    int plan_len;
    int issued;
    int cycles;
    int mismatches;
    int bytes_seen;
    int frames_seen;
    int refusals_seen;
    int settings_used;

    always #2 clk = ~clk;

    function automatic int active_leds();
        return (leds_reg > LED_SLOTS) ? LED_SLOTS : int'(leds_reg);
    endfunction

    function automatic int frame_bytes(input int leds);
        return START_BYTES + 4 * leds + (leds + END_ROUND) / 16 + 1;
    endfunction

    function automatic logic [BYTE_W-1:0] level_code();
        if (level_reg > LEVEL_MAX)
            return LEVEL_FULL;
        return LEVEL_MARK | {3'b000, level_reg[4:0] & LEVEL_MASK};
    endfunction

    function automatic logic [BYTE_W-1:0] frame_byte_at(input int pos, input int leds);
        int                  slot;
        logic [COLOUR_W-1:0] pix;
        if (pos < START_BYTES)
            return '0;
        slot = pos - START_BYTES;
        if (slot >= 4 * leds)
            return '0;
        pix = pixel_mem[slot >> 2];
        case (slot & 3)
            0:       return level_code();
            1:       return pix[7:0];
            2:       return pix[15:8];
            default: return pix[23:16];
        endcase
    endfunction

    function automatic strip_answer_t strip_step(input strip_req_t r);
        strip_answer_t a;
        int            leds;
        a = '0;
        case (r.kind)
            OP_WRITE:
                if (frame_is_open || r.pixel_index >= active_leds())
                    a.refused = 1'b1;
                else
                    pixel_mem[r.pixel_index] = r.colour;
            OP_CLEAR:
                if (frame_is_open)
                    a.refused = 1'b1;
                else
                    foreach (pixel_mem[i])
                        pixel_mem[i] = '0;
            OP_BYTE:
            begin
                leds = active_leds();
                if (!frame_is_open)
                begin
                    frame_is_open = 1'b1;
                    frame_pos     = 0;
                end
                a.frame_byte = frame_byte_at(frame_pos, leds);
                a.byte_valid = 1'b1;
                if (frame_pos + 1 >= frame_bytes(leds))
                begin
                    a.last_byte   = 1'b1;
                    frame_is_open = 1'b0;
                    frame_pos     = 0;
                end
                else
                begin
                    frame_pos++;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic void note_mismatch(input strip_answer_t want, input strip_answer_t got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
        begin
            $display("mismatch: expected byte %02h valid %0b last %0b refused %0b",
                     want.frame_byte, want.byte_valid, want.last_byte, want.refused);
            $display("          got      byte %02h valid %0b last %0b refused %0b",
                     got.frame_byte, got.byte_valid, got.last_byte, got.refused);
        end
    endfunction

    // drive requests and response readiness
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            if (!(req_ch.valid && !req_taken))
            begin
                if (send_queue.size() != 0 && $urandom_range(99) >= source_idle_pct)
                begin
                    req_ch.valid       <= 1'b1;
                    req_ch.kind        <= send_queue[0].kind;
                    req_ch.pixel_index <= send_queue[0].pixel_index;
                    req_ch.colour      <= send_queue[0].colour;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // track register writes, predict accepted requests, check responses
    always @(posedge clk)
    begin
        strip_req_t    r;
        strip_answer_t got;
        strip_answer_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BRIGHTNESS)
                    level_reg = cfg_data[BRIGHT_W-1:0];
                else if (cfg_index == CFG_LED_COUNT && !frame_is_open)
                    leds_reg = cfg_data[COUNT_W-1:0];
            end
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken)
            begin
                r.kind        = op_t'(req_ch.kind);
                r.pixel_index = req_ch.pixel_index;
                r.colour      = req_ch.colour;
                expected_answers.push_back(strip_step(r));
                void'(send_queue.pop_front());
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.frame_byte = rsp_ch.frame_byte;
                got.byte_valid = rsp_ch.byte_valid;
                got.last_byte  = rsp_ch.last_byte;
                got.refused    = rsp_ch.refused;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("unexpected response: byte %02h valid %0b last %0b refused %0b",
                                 got.frame_byte, got.byte_valid, got.last_byte, got.refused);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got !== want)
                        note_mismatch(want, got);
                end
                bytes_seen    += got.byte_valid;
                frames_seen   += got.last_byte;
                refusals_seen += got.refused;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d requests pending", cycles,
                     send_queue.size() + expected_answers.size());
            $display("rgb_led_strip_frame_builder test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (send_queue.size() != 0 || expected_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_strip(input logic [BRIGHT_W-1:0] level, input logic [COUNT_W-1:0] leds);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BRIGHTNESS;
        cfg_data  <= {1'b0, level};
        @(negedge clk);
        cfg_index <= CFG_LED_COUNT;
        cfg_data  <= leds;
        @(negedge clk);
        cfg_we    <= 1'b0;
        plan_len = frame_bytes(active_leds());
        plan_pos = frame_is_open ? frame_pos : 0;
        settings_used++;
    endtask

    task automatic push_req(input op_t kind, input logic [INDEX_W-1:0] idx,
                            input logic [COLOUR_W-1:0] colour);
        strip_req_t r;
        r.kind        = kind;
        r.pixel_index = idx;
        r.colour      = colour;
        send_queue.push_back(r);
        issued++;
        if (kind == OP_BYTE)
            plan_pos = (plan_pos + 1) % plan_len;
    endtask

    task automatic push_write(input logic [INDEX_W-1:0] idx);
        push_req(OP_WRITE, idx, COLOUR_W'($urandom_range(24'hFFFFFF)));
    endtask

    task automatic push_byte();
        push_req(OP_BYTE, INDEX_W'($urandom_range(255)), COLOUR_W'($urandom_range(24'hFFFFFF)));
    endtask

    task automatic close_frame();
        if (plan_pos != 0)
            repeat (plan_len - plan_pos) push_byte();
    endtask

    task automatic push_frame();
        repeat (plan_len) push_byte();
    endtask

    task automatic set_idling(input int source_pct, input int sink_pct);
        source_idle_pct = source_pct;
        sink_idle_pct   = sink_pct;
    endtask

    initial
    begin
        int                  act;
        int                  base;
        int                  target;
        logic [BRIGHT_W-1:0] level;
        logic [COUNT_W-1:0]  leds;

        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_BRIGHTNESS;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = OP_WRITE;
        req_ch.pixel_index = '0;
        req_ch.colour      = '0;
        rsp_ch.ready       = 1'b0;
        foreach (pixel_mem[i])
            pixel_mem[i] = '0;
        frame_pos     = 0;
        frame_is_open = 1'b0;
        level_reg     = BRIGHTNESS_RESET;
        leds_reg      = '0;
        set_idling(19, 52);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // clamped brightness, writes in and out of range, refusals while a frame is open
        set_strip(8'd255, 9'd3);
        push_req(OP_CLEAR, 8'd0, 24'd0);
        push_req(OP_WRITE, 8'd0, 24'hFFFFFF);
        push_req(OP_WRITE, 8'd1, 24'hA5C3E1);
        push_req(OP_WRITE, 8'd2, 24'h000001);
        push_write(8'd3);
        push_write(8'd255);
        push_req(OP_NONE, 8'hFF, 24'hFFFFFF);
        repeat (5) push_byte();
        push_write(8'd0);
        push_req(OP_CLEAR, 8'd0, 24'd0);
        close_frame();

        // empty strip
        set_strip(8'd0, 9'd0);
        push_write(8'd0);
        push_frame();

        // count write ignored and brightness taken up mid-frame
        set_strip(8'd32, 9'd17);
        push_write(8'd16);
        push_write(8'd17);
        repeat (10) push_byte();
        set_strip(8'd5, 9'd1);
        close_frame();

        base = issued;
        while (issued - base < RANDOM_ITEMS)
        begin
            if (issued - base < RANDOM_ITEMS / 3)
                set_idling(19, 52);
            else if (issued - base < 2 * RANDOM_ITEMS / 3)
                set_idling(52, 19);
            else
                set_idling(0, 0);
            case ($urandom_range(4))
                0:       level = 8'd0;
                1:       level = 8'd31;
                2:       level = 8'd32;
                3:       level = 8'd255;
                default: level = BRIGHT_W'($urandom_range(255));
            endcase
            case ($urandom_range(7))
                0:       leds = 9'd0;
                1:       leds = 9'd1;
                2:       leds = 9'd16;
                3:       leds = 9'd17;
                default: leds = COUNT_W'($urandom_range(2, 12));
            endcase
            set_strip(level, leds);
            act    = active_leds();
            target = issued + 80;
            while (issued < target)
            begin
                if ($urandom_range(99) < 75)
                begin
                    close_frame();
                    if ($urandom_range(99) < 10)
                        push_req(OP_CLEAR, INDEX_W'($urandom_range(255)),
                                 COLOUR_W'($urandom_range(24'hFFFFFF)));
                    if (act > 0)
                        repeat ($urandom_range(1, 6)) push_write(INDEX_W'($urandom_range(act - 1)));
                    if ($urandom_range(99) < 30)
                        push_write(INDEX_W'($urandom_range(act, 255)));
                    push_frame();
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        push_req(op_t'($urandom_range(3)), INDEX_W'($urandom_range(255)),
                                 COLOUR_W'($urandom_range(24'hFFFFFF)));
                end
            end
        end

        // count beyond the store acts as a full store
        close_frame();
        set_strip(BRIGHT_W'($urandom_range(1, 30)), 9'd511);
        push_write(8'd255);
        push_write(8'd0);
        push_write(8'd128);
        push_req(OP_NONE, 8'd0, 24'd0);
        repeat (FULL_BYTES) push_byte();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        mismatches += expected_answers.size();

        $display("covered %0d requests over %0d strip settings in %0d cycles",
                 issued, settings_used, cycles);
        $display("checked %0d frame bytes, %0d complete frames, %0d refusals",
                 bytes_seen, frames_seen, refusals_seen);
        if (mismatches == 0)
            $display("rgb_led_strip_frame_builder test passed");
        else
            $display("rgb_led_strip_frame_builder test failed");
        $finish;
    end

endmodule
